// ===== sv/assert_macros.svh =====
// Assertion macros used by the multiply/divide unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/fmdu_pkg.sv =====
// Constants and pipeline record types of the fixed-point multiply/divide unit.
package fmdu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int QUO_BITS  = WORD_W - 1;
    localparam int DIV_SHIFT = QUO_BITS - FRAC_BITS;
    localparam int WIDE_W    = 2 * WORD_W - 1;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int N_ITER    = QUO_BITS;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              neg;
        logic              nz;
        logic [WORD_W-1:0] ma;
        logic [WORD_W-1:0] mb;
    } t_s1;

    typedef struct packed {
        t_op                 op;
        logic                neg;
        logic                ovf;
        logic                minq;
        logic [PROD_W-1:0]   prod;
        logic [WORD_W-1:0]   den;
        logic [WORD_W-1:0]   rem;
        logic [QUO_BITS-1:0] nlo;
    } t_s2;

    typedef struct packed {
        t_op                 op;
        logic                neg;
        logic                ovf;
        logic                minq;
        logic [WORD_W-1:0]   den;
        logic [WORD_W-1:0]   rem;
        logic [QUO_BITS-1:0] nlo;
        logic [WORD_W-1:0]   res;
    } t_it;

endpackage

// ===== sv/fixed_16_16_mul_div_unit.sv =====
// Pipelined signed 16.16 fixed-point multiply and divide unit.
//
// Input channel: i_valid with i_operation, i_lhs, i_rhs; o_stall holds it off.
// A transaction is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with o_result, o_overflow; i_stall holds it off.
// Multiply returns the product shifted right by 16, low 32 bits, wrapping.
// Divide returns (lhs * 65536) / rhs truncated toward zero; a zero divisor
// or an exact quotient outside the signed 32-bit range gives 0 with o_overflow set.
// Both operations pass through the same stages on the way to o_valid:
// operand register, magnitude stage, multiplier and range check stage, one
// restoring divide stage per quotient bit (31), and the output register.
// One transaction per cycle while o_stall is low; each stage holds its own.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; only then does o_stall rise and the whole
// pipeline freeze until the skid register drains.
// Reset empties the pipeline, the output and the skid register.
module fixed_16_16_mul_div_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic signed [fmdu_pkg::WORD_W-1:0]  i_lhs,
    input  logic signed [fmdu_pkg::WORD_W-1:0]  i_rhs,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fmdu_pkg::WORD_W-1:0]  o_result,
    output logic                                o_overflow
);

`include "assert_macros.svh"

    function automatic fmdu_pkg::t_it f_step(input fmdu_pkg::t_it x);
        fmdu_pkg::t_it           y;
        logic [fmdu_pkg::WORD_W:0] rem_sh;
        logic [fmdu_pkg::WORD_W:0] diff;
        logic                      ge;
        y      = x;
        rem_sh = {x.rem, x.nlo[fmdu_pkg::QUO_BITS-1]};
        diff   = rem_sh - {1'b0, x.den};
        ge     = !diff[fmdu_pkg::WORD_W];
        if (x.op == fmdu_pkg::OP_DIV) begin
            y.rem = ge ? diff[fmdu_pkg::WORD_W-1:0] : rem_sh[fmdu_pkg::WORD_W-1:0];
            y.res = {x.res[fmdu_pkg::WORD_W-2:0], ge};
            y.nlo = {x.nlo[fmdu_pkg::QUO_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

    logic                          en;
    logic                          r_vld0;
    fmdu_pkg::t_op                 r_op0;
    logic [fmdu_pkg::WORD_W-1:0]   r_lhs0;
    logic [fmdu_pkg::WORD_W-1:0]   r_rhs0;
    logic                          r_vld1;
    fmdu_pkg::t_s1                 r_s1;
    fmdu_pkg::t_s1                 n_s1;
    logic                          r_vld2;
    fmdu_pkg::t_s2                 r_s2;
    fmdu_pkg::t_s2                 n_s2;
    logic [fmdu_pkg::N_ITER-1:0]   r_vld_it;
    fmdu_pkg::t_it                 r_it [fmdu_pkg::N_ITER];
    fmdu_pkg::t_it                 n_it [fmdu_pkg::N_ITER];
    fmdu_pkg::t_it                 it_in;
    logic [fmdu_pkg::PROD_W-1:0]   sprod;
    logic [fmdu_pkg::WIDE_W-1:0]   lhs_w;
    logic [fmdu_pkg::WIDE_W-1:0]   rhs_w;
    logic [fmdu_pkg::WIDE_W-1:0]   num_w;
    logic                          big;
    logic                          exact;
    logic                          dneg;
    logic                          dovf;
    fmdu_pkg::t_it                 last;
    logic                          p_vld;
    logic [fmdu_pkg::WORD_W-1:0]   p_res;
    logic                          p_ovf;
    logic                          out_free;
    logic                          r_out_vld;
    logic [fmdu_pkg::WORD_W-1:0]   r_out_res;
    logic                          r_out_ovf;
    logic                          r_skid_vld;
    logic [fmdu_pkg::WORD_W-1:0]   r_skid_res;
    logic                          r_skid_ovf;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_comb begin
        n_s1.op  = r_op0;
        n_s1.neg = r_lhs0[fmdu_pkg::WORD_W-1] ^ r_rhs0[fmdu_pkg::WORD_W-1];
        n_s1.ma  = r_lhs0[fmdu_pkg::WORD_W-1] ? (~r_lhs0 + 1'b1) : r_lhs0;
        n_s1.mb  = r_rhs0[fmdu_pkg::WORD_W-1] ? (~r_rhs0 + 1'b1) : r_rhs0;
        n_s1.nz  = |n_s1.ma;
    end

    always_comb begin
        lhs_w = fmdu_pkg::WIDE_W'(r_s1.ma);
        rhs_w = fmdu_pkg::WIDE_W'(r_s1.mb) << fmdu_pkg::DIV_SHIFT;
        num_w = fmdu_pkg::WIDE_W'(r_s1.ma) << fmdu_pkg::FRAC_BITS;
        big   = lhs_w >= rhs_w;
        exact = lhs_w == rhs_w;
        dneg  = r_s1.neg && r_s1.nz;
        dovf  = (r_s1.mb == '0) || (big && !(dneg && exact));
        n_s2.op   = r_s1.op;
        n_s2.prod = fmdu_pkg::PROD_W'(r_s1.ma) * fmdu_pkg::PROD_W'(r_s1.mb);
        n_s2.den  = r_s1.mb;
        n_s2.rem  = fmdu_pkg::WORD_W'(r_s1.ma >> fmdu_pkg::DIV_SHIFT);
        n_s2.nlo  = num_w[fmdu_pkg::QUO_BITS-1:0];
        if (r_s1.op == fmdu_pkg::OP_DIV) begin
            n_s2.neg  = dneg;
            n_s2.ovf  = dovf;
            n_s2.minq = !dovf && big;
        end else begin
            n_s2.neg  = r_s1.neg;
            n_s2.ovf  = 1'b0;
            n_s2.minq = 1'b0;
        end
    end

    always_comb begin
        sprod       = r_s2.neg ? (~r_s2.prod + 1'b1) : r_s2.prod;
        it_in.op    = r_s2.op;
        it_in.neg   = r_s2.neg;
        it_in.ovf   = r_s2.ovf;
        it_in.minq  = r_s2.minq;
        it_in.den   = r_s2.den;
        it_in.rem   = r_s2.rem;
        it_in.nlo   = r_s2.nlo;
        it_in.res   = (r_s2.op == fmdu_pkg::OP_MUL) ?
                      sprod[fmdu_pkg::FRAC_BITS +: fmdu_pkg::WORD_W] : '0;
        n_it[0] = f_step(it_in);
        for (int k = 1; k < fmdu_pkg::N_ITER; k++) begin
            n_it[k] = f_step(r_it[k-1]);
        end
    end

    always_comb begin
        last  = r_it[fmdu_pkg::N_ITER-1];
        p_vld = en && r_vld_it[fmdu_pkg::N_ITER-1];
        p_ovf = last.ovf;
        if (last.ovf) begin
            p_res = '0;
        end else if (last.minq) begin
            p_res = {1'b1, {fmdu_pkg::QUO_BITS{1'b0}}};
        end else if (last.op == fmdu_pkg::OP_DIV && last.neg) begin
            p_res = ~last.res + 1'b1;
        end else begin
            p_res = last.res;
        end
        out_free = !r_out_vld || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0   <= 1'b0;
            r_vld1   <= 1'b0;
            r_vld2   <= 1'b0;
            r_vld_it <= '0;
        end else if (en) begin
            r_vld0   <= i_valid;
            r_vld1   <= r_vld0;
            r_vld2   <= r_vld1;
            r_vld_it <= {r_vld_it[fmdu_pkg::N_ITER-2:0], r_vld2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op0  <= fmdu_pkg::t_op'(i_operation);
            r_lhs0 <= i_lhs;
            r_rhs0 <= i_rhs;
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            for (int k = 0; k < fmdu_pkg::N_ITER; k++) begin
                r_it[k] <= n_it[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld  <= r_skid_vld || p_vld;
            r_skid_vld <= 1'b0;
        end else if (p_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_res <= r_skid_vld ? r_skid_res : p_res;
            r_out_ovf <= r_skid_vld ? r_skid_ovf : p_ovf;
        end else if (p_vld) begin
            r_skid_res <= p_res;
            r_skid_ovf <= p_ovf;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_result   = r_out_res;
    assign o_overflow = r_out_ovf;

    `ASSERT_ALWAYS(a_skid_needs_out, r_skid_vld |-> r_out_vld, "skid full with empty output")
    `ASSERT_CLK(a_skid_on_stall, $rose(r_skid_vld) |-> $past(r_out_vld && i_stall), "skid filled without stall")
    `ASSERT_CLK(a_ovf_zero, (o_valid && o_overflow) |-> (o_result == '0), "overflow with nonzero result")
    `ASSERT_CLK(a_mul_no_ovf, (r_vld_it[fmdu_pkg::N_ITER-1] && last.op == fmdu_pkg::OP_MUL) |-> !last.ovf, "multiply flagged overflow")

endmodule
